// File: design/bfhp_pkg.sv
// ----------------------------------------------------------------------------
// bfhp_pkg
// Types, codes and helper functions of the binary frame header parser.
// ----------------------------------------------------------------------------
package bfhp_pkg;

	localparam logic [1:0] K_PUSH      = 2'd0;
	localparam logic [1:0] K_REPLY     = 2'd1;
	localparam logic [1:0] K_BROADCAST = 2'd2;

	localparam logic [3:0] PH_KIND = 4'd0;
	localparam logic [3:0] PH_LEN0 = 4'd1;
	localparam logic [3:0] PH_FLD0 = 4'd5;
	localparam logic [3:0] PH_PAY  = 4'd9;

	localparam logic [2:0] TAG_NONE    = 3'd0;
	localparam logic [2:0] TAG_REF     = 3'd1;
	localparam logic [2:0] TAG_TOPIC   = 3'd2;
	localparam logic [2:0] TAG_EVENT   = 3'd3;
	localparam logic [2:0] TAG_STATUS  = 3'd4;
	localparam logic [2:0] TAG_PAYLOAD = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam int NUM_LEN = 4;

	typedef logic [7:0] len_arr_t [NUM_LEN];

	typedef struct packed {
		logic [3:0] phase;
		logic [1:0] kind;
		logic [7:0] remaining;
		logic       discarding;
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] tag;
		logic [7:0] data;
		logic [1:0] kind;
		logic       frame_end;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] remaining;
	} seek_t;

	function automatic logic [2:0] num_fields(input logic [1:0] kind);
		logic [2:0] n;
		case (kind)
			K_PUSH:      n = 3'd3;
			K_REPLY:     n = 3'd4;
			K_BROADCAST: n = 3'd2;
			default:     n = 3'd3;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] field_tag_of(input logic [1:0] kind, input logic [1:0] k);
		logic [2:0] t;
		t = TAG_NONE;
		case (kind)
			K_REPLY: begin
				case (k)
					2'd1:    t = TAG_REF;
					2'd2:    t = TAG_TOPIC;
					2'd3:    t = TAG_STATUS;
					default: t = TAG_NONE;
				endcase
			end
			K_BROADCAST: begin
				case (k)
					2'd0:    t = TAG_TOPIC;
					2'd1:    t = TAG_EVENT;
					default: t = TAG_NONE;
				endcase
			end
			default: begin
				case (k)
					2'd1:    t = TAG_TOPIC;
					2'd2:    t = TAG_EVENT;
					default: t = TAG_NONE;
				endcase
			end
		endcase
		return t;
	endfunction

	// first nonempty field at index start or later, else payload
	function automatic seek_t seek_field(input logic [1:0] kind, input logic [2:0] start,
			input len_arr_t lens);
		seek_t      s;
		logic       found;
		logic [2:0] n;
		n = num_fields(kind);
		found = 1'b0;
		s.phase = PH_PAY;
		s.remaining = 8'd0;
		for (int i = 0; i < NUM_LEN; i++) begin
			if (!found && 3'(i) >= start && 3'(i) < n && lens[i] != 8'd0) begin
				found = 1'b1;
				s.phase = PH_FLD0 + 4'(i);
				s.remaining = lens[i];
			end
		end
		return s;
	endfunction

endpackage

// File: design/bfhp_step.sv
// ----------------------------------------------------------------------------
// bfhp_step
// Next-state and result logic for one frame byte.
// ----------------------------------------------------------------------------
module bfhp_step (
	input  bfhp_pkg::state_t   cur,
	input  bfhp_pkg::len_arr_t lens,
	input  logic [7:0]         data_byte,
	input  logic               frame_last,
	output bfhp_pkg::state_t   nxt,
	output logic               len_we,
	output logic [1:0]         len_idx,
	output bfhp_pkg::result_t  res
);

	logic [1:0]         kind;
	logic [1:0]         k;
	logic [2:0]         tag;
	logic [7:0]         rem_dec;
	bfhp_pkg::len_arr_t lens_n;
	bfhp_pkg::seek_t    sk;

	always_comb begin
		kind    = (cur.kind == 2'd3) ? bfhp_pkg::K_PUSH : cur.kind;
		nxt     = cur;
		len_we  = 1'b0;
		len_idx = 2'd0;
		res     = '0;
		k       = 2'd0;
		tag     = bfhp_pkg::TAG_NONE;
		rem_dec = cur.remaining - 8'd1;
		lens_n  = lens;
		sk      = '0;

		if (cur.discarding) begin
			if (frame_last) begin
				res.valid     = 1'b1;
				res.frame_end = 1'b1;
				res.status    = bfhp_pkg::ST_UNKNOWN;
				nxt.phase      = bfhp_pkg::PH_KIND;
				nxt.discarding = 1'b0;
			end
		end else if (cur.phase >= bfhp_pkg::PH_LEN0 && cur.phase < bfhp_pkg::PH_FLD0) begin
			k         = 2'(cur.phase - bfhp_pkg::PH_LEN0);
			len_we    = 1'b1;
			len_idx   = k;
			lens_n[k] = data_byte;
			if ({1'b0, k} + 3'd1 < bfhp_pkg::num_fields(kind)) begin
				nxt.phase = cur.phase + 4'd1;
			end else begin
				sk            = bfhp_pkg::seek_field(kind, 3'd0, lens_n);
				nxt.phase     = sk.phase;
				nxt.remaining = sk.remaining;
			end
			if (frame_last) begin
				res.valid     = 1'b1;
				res.kind      = kind;
				res.frame_end = 1'b1;
				res.status    = (nxt.phase == bfhp_pkg::PH_PAY) ? bfhp_pkg::ST_OK
					: bfhp_pkg::ST_TRUNC;
				nxt.phase      = bfhp_pkg::PH_KIND;
				nxt.discarding = 1'b0;
			end
		end else if (cur.phase >= bfhp_pkg::PH_FLD0 && cur.phase < bfhp_pkg::PH_PAY) begin
			k             = 2'(cur.phase - bfhp_pkg::PH_FLD0);
			tag           = bfhp_pkg::field_tag_of(kind, k);
			nxt.remaining = rem_dec;
			if (rem_dec == 8'd0) begin
				sk            = bfhp_pkg::seek_field(kind, {1'b0, k} + 3'd1, lens);
				nxt.phase     = sk.phase;
				nxt.remaining = sk.remaining;
			end
			if (frame_last) begin
				res.valid     = 1'b1;
				res.kind      = kind;
				res.frame_end = 1'b1;
				if (nxt.phase == bfhp_pkg::PH_PAY) begin
					res.tag    = tag;
					res.data   = (tag != bfhp_pkg::TAG_NONE) ? data_byte : 8'd0;
					res.status = bfhp_pkg::ST_OK;
				end else begin
					res.status = bfhp_pkg::ST_TRUNC;
				end
				nxt.phase      = bfhp_pkg::PH_KIND;
				nxt.discarding = 1'b0;
			end else if (tag != bfhp_pkg::TAG_NONE) begin
				res.valid = 1'b1;
				res.tag   = tag;
				res.data  = data_byte;
				res.kind  = kind;
			end
		end else if (cur.phase == bfhp_pkg::PH_PAY) begin
			res.valid     = 1'b1;
			res.tag       = bfhp_pkg::TAG_PAYLOAD;
			res.data      = data_byte;
			res.kind      = kind;
			res.frame_end = frame_last;
			if (frame_last) begin
				nxt.phase      = bfhp_pkg::PH_KIND;
				nxt.discarding = 1'b0;
			end
		end else begin
			// kind byte; unused phase codes land here too
			if (data_byte > {6'd0, bfhp_pkg::K_BROADCAST}) begin
				nxt.kind = bfhp_pkg::K_PUSH;
				if (frame_last) begin
					res.valid      = 1'b1;
					res.frame_end  = 1'b1;
					res.status     = bfhp_pkg::ST_UNKNOWN;
					nxt.phase      = bfhp_pkg::PH_KIND;
					nxt.discarding = 1'b0;
				end else begin
					nxt.discarding = 1'b1;
				end
			end else begin
				nxt.kind  = data_byte[1:0];
				nxt.phase = bfhp_pkg::PH_LEN0;
				if (frame_last) begin
					res.valid      = 1'b1;
					res.kind       = data_byte[1:0];
					res.frame_end  = 1'b1;
					res.status     = bfhp_pkg::ST_TRUNC;
					nxt.phase      = bfhp_pkg::PH_KIND;
					nxt.discarding = 1'b0;
				end
			end
		end
	end

endmodule

// File: design/binary_frame_header_parser_top.sv
// ----------------------------------------------------------------------------
// binary_frame_header_parser_top
// Length-prefixed binary frame header parser, one byte per item.
// ----------------------------------------------------------------------------
// The result of an accepted byte is in the output register in the next cycle.
// Throughput: one byte per cycle; the output register stalls input only while
// it holds a result that is not taken.
// Reset: arst_n clears parse state and the output valid; field lengths are
// not reset, they are always written before use within a frame.
module binary_frame_header_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] field_tag,
	output logic [7:0] out_byte,
	output logic [1:0] frame_kind,
	output logic       frame_end,
	output logic [1:0] status
);

	bfhp_pkg::state_t   state_q;
	bfhp_pkg::state_t   state_nxt;
	bfhp_pkg::len_arr_t lens_q;
	bfhp_pkg::result_t  res;
	logic               len_we;
	logic [1:0]         len_idx;
	logic               accept;
	logic               out_valid_q;
	logic [2:0]         tag_q;
	logic [7:0]         byte_q;
	logic [1:0]         kind_q;
	logic               end_q;
	logic [1:0]         status_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	bfhp_step u_step (
		.cur        (state_q),
		.lens       (lens_q),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.nxt        (state_nxt),
		.len_we     (len_we),
		.len_idx    (len_idx),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= bfhp_pkg::PH_KIND;
			state_q.kind       <= bfhp_pkg::K_PUSH;
			state_q.remaining  <= 8'd0;
			state_q.discarding <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= res.valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && len_we) begin
			lens_q[len_idx] <= data_byte;
		end
		if (accept && res.valid) begin
			tag_q    <= res.tag;
			byte_q   <= res.data;
			kind_q   <= res.kind;
			end_q    <= res.frame_end;
			status_q <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign field_tag  = tag_q;
	assign out_byte   = byte_q;
	assign frame_kind = kind_q;
	assign frame_end  = end_q;
	assign status     = status_q;

endmodule

// File: bench/frame_checker.sv
// ----------------------------------------------------------------------------
// frame_checker
// Watches both channels of the frame header parser and predicts the tagged
// output bytes of every accepted input byte. Each accepted result is compared
// field by field with the oldest prediction; mismatches are counted.
// ----------------------------------------------------------------------------
module frame_checker
	import bfhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [2:0] field_tag,
	input  logic [7:0] out_byte,
	input  logic [1:0] frame_kind,
	input  logic       frame_end,
	input  logic [1:0] status,
	output int         mismatch_count,
	output int         pending
);

	typedef struct packed {
		logic [2:0] tag;
		logic [7:0] data;
		logic [1:0] kind;
		logic       fend;
		logic [1:0] st;
	} parsed_t;

	parsed_t    parsed_q[$];
	parsed_t    head;
	logic [3:0] phase_r;
	logic [1:0] kind_r;
	logic [7:0] len_r [NUM_LEN];
	logic [7:0] left_r;
	logic       skip_r;

	assign pending = parsed_q.size();

	function automatic logic [2:0] field_count(input logic [1:0] kind);
		case (kind)
			K_REPLY:     return 3'd4;
			K_BROADCAST: return 3'd2;
			default:     return 3'd3;
		endcase
	endfunction

	function automatic logic [2:0] tag_for(input logic [1:0] kind, input logic [1:0] k);
		logic [2:0] tags [4];
		case (kind)
			K_REPLY:     tags = '{TAG_NONE, TAG_REF, TAG_TOPIC, TAG_STATUS};
			K_BROADCAST: tags = '{TAG_TOPIC, TAG_EVENT, TAG_NONE, TAG_NONE};
			default:     tags = '{TAG_NONE, TAG_TOPIC, TAG_EVENT, TAG_NONE};
		endcase
		return tags[k];
	endfunction

	function automatic parsed_t mk(input logic [2:0] tag, input logic [7:0] b,
			input logic [1:0] kind, input logic fend, input logic [1:0] st);
		parsed_t r;
		r.tag  = tag;
		r.data = (tag == TAG_NONE) ? 8'd0 : b;
		r.kind = kind;
		r.fend = fend;
		r.st   = st;
		return r;
	endfunction

	// skip empty fields; fall through to payload
	task automatic next_field(input logic [1:0] kind, input int from);
		int k;
		k = from;
		while (k < int'(field_count(kind)) && len_r[k] == 8'd0)
			k++;
		if (k < int'(field_count(kind))) begin
			phase_r = PH_FLD0 + 4'(k);
			left_r  = len_r[k];
		end else begin
			phase_r = PH_PAY;
			left_r  = 8'd0;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		parsed_t    r;
		logic       emit;
		logic [1:0] kind;
		int         k;
		logic [2:0] tg;
		r    = '0;
		emit = 1'b0;
		kind = (kind_r == 2'd3) ? K_PUSH : kind_r;
		if (skip_r) begin
			if (last) begin
				r    = mk(TAG_NONE, 8'd0, K_PUSH, 1'b1, ST_UNKNOWN);
				emit = 1'b1;
			end
		end else if (phase_r >= PH_LEN0 && phase_r < PH_FLD0) begin
			k = int'(phase_r - PH_LEN0);
			len_r[k] = b;
			if (k + 1 < int'(field_count(kind)))
				phase_r = phase_r + 4'd1;
			else
				next_field(kind, 0);
			if (last) begin
				r    = mk(TAG_NONE, 8'd0, kind, 1'b1, (phase_r == PH_PAY) ? ST_OK : ST_TRUNC);
				emit = 1'b1;
			end
		end else if (phase_r >= PH_FLD0 && phase_r < PH_PAY) begin
			k  = int'(phase_r - PH_FLD0);
			tg = tag_for(kind, 2'(k));
			left_r = left_r - 8'd1;
			if (left_r == 8'd0)
				next_field(kind, k + 1);
			if (last) begin
				if (phase_r == PH_PAY)
					r = mk(tg, b, kind, 1'b1, ST_OK);
				else
					r = mk(TAG_NONE, 8'd0, kind, 1'b1, ST_TRUNC);
				emit = 1'b1;
			end else if (tg != TAG_NONE) begin
				r    = mk(tg, b, kind, 1'b0, ST_OK);
				emit = 1'b1;
			end
		end else if (phase_r == PH_PAY) begin
			r    = mk(TAG_PAYLOAD, b, kind, last, ST_OK);
			emit = 1'b1;
		end else if (b > 8'(K_BROADCAST)) begin
			kind_r = K_PUSH;
			if (last) begin
				r    = mk(TAG_NONE, 8'd0, K_PUSH, 1'b1, ST_UNKNOWN);
				emit = 1'b1;
			end else begin
				skip_r = 1'b1;
			end
		end else begin
			kind_r  = b[1:0];
			phase_r = PH_LEN0;
			if (last) begin
				r    = mk(TAG_NONE, 8'd0, b[1:0], 1'b1, ST_TRUNC);
				emit = 1'b1;
			end
		end
		// every path closes the frame on its last byte
		if (last) begin
			phase_r = PH_KIND;
			skip_r  = 1'b0;
		end
		if (emit)
			parsed_q.push_back(r);
	endtask

	task automatic compare(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parsed_q.delete();
			phase_r        = PH_KIND;
			kind_r         = K_PUSH;
			left_r         = 8'd0;
			skip_r         = 1'b0;
			mismatch_count = 0;
			foreach (len_r[i])
				len_r[i] = 8'd0;
		end else begin
			// output first: it belongs to an item taken on an earlier edge
			if (out_valid && out_ready) begin
				if (parsed_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected item, expected none, actual tag %0d byte %0d end %0d",
						$time, field_tag, out_byte, frame_end);
				end else begin
					head = parsed_q.pop_front();
					compare("field_tag", head.tag, field_tag);
					compare("out_byte", head.data, out_byte);
					compare("frame_kind", head.kind, frame_kind);
					compare("frame_end", head.fend, frame_end);
					compare("status", head.st, status);
				end
			end
			if (in_valid && in_ready)
				parse_byte(data_byte, frame_last);
		end
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives binary frames into the frame header parser: a few directed frames
// for kinds, empty fields, dropped bytes, early end and unknown kind, then
// random well-formed, truncated, unknown-kind and noise frames under three
// idling profiles. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import bfhp_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [7:0] B_PUSH      = 8'(K_PUSH);
	localparam logic [7:0] B_REPLY     = 8'(K_REPLY);
	localparam logic [7:0] B_BCAST     = 8'(K_BROADCAST);

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       frame_last;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] field_tag;
	logic [7:0] out_byte;
	logic [1:0] frame_kind;
	logic       frame_end;
	logic [1:0] status;

	int         mismatch_count;
	int         pending;
	int         cycle_count = 0;
	int         sent_count  = 0;
	int         gap_pct     = 21;
	int         rx_pct      = 56;
	logic [7:0] frame_q[$];

	binary_frame_header_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.field_tag  (field_tag),
		.out_byte   (out_byte),
		.frame_kind (frame_kind),
		.frame_end  (frame_end),
		.status     (status)
	);

	frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_tag      (field_tag),
		.out_byte       (out_byte),
		.frame_kind     (frame_kind),
		.frame_end      (frame_end),
		.status         (status),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_pct);
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		frame_last <= last;
		do
			@(posedge clk);
		while (!in_ready);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly short fields, rarely very long ones
	function automatic logic [7:0] rand_len();
		int p;
		p = $urandom_range(999);
		if (p < 200)
			return 8'd0;
		if (p < 900)
			return 8'($urandom_range(6, 1));
		if (p < 995)
			return 8'($urandom_range(40, 7));
		return $urandom_range(1) ? 8'd255 : 8'($urandom_range(254, 100));
	endfunction

	task automatic make_frame();
		int         sel;
		int         nf;
		int         cut;
		logic [1:0] kind;
		logic [7:0] lens [4];
		sel = $urandom_range(99);
		frame_q.delete();
		if (sel < 7) begin
			frame_q.push_back(8'($urandom_range(255, 3)));
			repeat ($urandom_range(10))
				frame_q.push_back(8'($urandom));
		end else if (sel < 10) begin
			repeat ($urandom_range(10, 1))
				frame_q.push_back(8'($urandom));
		end else begin
			kind = 2'($urandom_range(2));
			nf = (kind == K_REPLY) ? 4 : (kind == K_BROADCAST) ? 2 : 3;
			frame_q.push_back(8'(kind));
			for (int i = 0; i < nf; i++) begin
				lens[i] = rand_len();
				frame_q.push_back(lens[i]);
			end
			for (int i = 0; i < nf; i++)
				repeat (lens[i])
					frame_q.push_back(8'($urandom));
			repeat ($urandom_range(8))
				frame_q.push_back(8'($urandom));
			if (sel < 22) begin
				cut = $urandom_range(frame_q.size() - 1, 1);
				while (frame_q.size() > cut)
					void'(frame_q.pop_back());
			end
		end
	endtask

	task automatic run_random(input int budget);
		int start;
		start = sent_count;
		while (sent_count - start < budget) begin
			make_frame();
			send_frame();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		data_byte  = 8'd0;
		frame_last = 1'b0;
		out_ready  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		frame_q = '{B_PUSH};
		send_frame();
		frame_q = '{8'hFF};
		send_frame();
		frame_q = '{8'h03, 8'h7F};
		send_frame();
		frame_q = '{B_BCAST, 8'h00, 8'h00};
		send_frame();
		frame_q = '{B_REPLY, 8'h01, 8'h01, 8'h01, 8'h01, 8'hA5, 8'hFF, 8'h00, 8'h5A, 8'h80};
		send_frame();
		frame_q = '{B_BCAST, 8'h00, 8'h01, 8'h33};
		send_frame();
		frame_q = '{B_PUSH, 8'h01, 8'h00, 8'h00, 8'hC3};
		send_frame();
		drain();

		run_random(530);
		drain();
		gap_pct = 56;
		rx_pct  = 21;
		run_random(530);
		drain();
		gap_pct = 0;
		rx_pct  = 0;
		run_random(540);
		drain();

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
design/bfhp_pkg.sv
design/bfhp_step.sv
design/binary_frame_header_parser_top.sv
bench/frame_checker.sv
bench/testbench.sv
